// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty bodies for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define EGC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define EGC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define EGC_ASSERT(lbl, clk, rst_n, prop, msg)
`define EGC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== design/egc_pkg.sv =====
// ----------------------------------------------------------------------------
// egc_pkg
// shared types, defaults and elaboration-time constant builders
// ----------------------------------------------------------------------------
package egc_pkg;

  localparam int ANGLE_BITS_DEF    = 32;
  localparam int CORDIC_STAGES_DEF = 30;
  localparam int COEF_BITS_DEF     = 32;

  localparam logic [63:0] PI60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] TWOPI60   = 64'h6487ED5110B4611A;
  localparam logic [63:0] DEG_SCALE = 64'd36000000;

  // euler angles in degrees times 1e5
  localparam longint DEG_A = -64'sd28285920;
  localparam longint DEG_B = -64'sd6287170;
  localparam longint DEG_C = 64'sd3293224;

  typedef logic [8:0][63:0] mat_t;
  typedef logic [1:0][63:0] pair_t;

  typedef struct packed {
    logic valid;
    logic req;
    logic neg_lon;
    logic neg_lat;
  } rot_ctl_t;

  typedef struct packed {
    logic valid;
    logic pole;
  } vec_ctl_t;

  // floor(a * 2^k / b), a < b
  function automatic logic [63:0] frac_div(input logic [63:0] a, input logic [63:0] b,
                                           input int k);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = a;
    for (int i = 0; i < k; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= b) begin
        r    = r - b;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // integer quotient by long division
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in turns, rounded to nearest
  function automatic logic [63:0] atan_tab(input int i, input int ab);
    logic [63:0] rad;
    logic [63:0] term;
    int          sh;
    rad = '0;
    if (i == 0) begin
      rad = PI60 >> 2;
    end else begin
      for (int k = 0; k < 64; k++) begin
        sh = i * (2 * k + 1);
        if (sh >= 60) break;
        term = udiv(64'd1 << (60 - sh), 64'(2 * k + 1));
        if ((k & 1) != 0) rad = rad - term;
        else rad = rad + term;
      end
    end
    return (frac_div(rad, TWOPI60, ab + 1) + 64'd1) >> 1;
  endfunction

  function automatic longint to_signed(input logic [63:0] a, input int ab);
    logic [63:0] mask;
    logic [63:0] v;
    mask = (64'd1 << ab) - 64'd1;
    v    = a & mask;
    if (v[ab-1]) return longint'(v) - longint'(mask) - 64'sd1;
    return longint'(v);
  endfunction

  // rotation-mode cordic, returns {cos, sin} times gain times x0
  function automatic pair_t rotate_c(input logic [63:0] ang, input longint x0,
                                     input int ab, input int ns);
    logic [63:0] mask;
    logic [63:0] half;
    logic [63:0] quarter;
    logic [63:0] a;
    logic        neg;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    pair_t       p;
    mask    = (64'd1 << ab) - 64'd1;
    half    = 64'd1 << (ab - 1);
    quarter = 64'd1 << (ab - 2);
    a       = ang & mask;
    neg     = 1'b0;
    if (((a + quarter) & mask) >= half) begin
      a   = (a - half) & mask;
      neg = 1'b1;
    end
    z = to_signed(a, ab);
    x = x0;
    y = 0;
    for (int i = 0; i < ns; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(atan_tab(i, ab));
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(atan_tab(i, ab));
      end
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    p[1] = x;
    p[0] = y;
    return p;
  endfunction

  // product with round half away from zero
  function automatic longint mulq_c(input longint a, input longint b, input int frac);
    logic         neg;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? 64'(-a) : 64'(a);
    ub  = (b < 0) ? 64'(-b) : 64'(b);
    p   = {64'd0, ua} * {64'd0, ub};
    p   = p + (128'd1 << (frac - 1));
    p   = p >> frac;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic [63:0] deg_to_ang(input longint d, input int ab);
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] mask;
    mask = (64'd1 << ab) - 64'd1;
    m    = (d < 0) ? 64'(-d) : 64'(d);
    q    = (frac_div(m, DEG_SCALE, ab + 1) + 64'd1) >> 1;
    return ((d < 0) ? (64'd0 - q) : q) & mask;
  endfunction

  // inverse cordic gain
  function automatic longint kfix_c(input int ab, input int ns, input int cb);
    pair_t g;
    g = rotate_c(64'd0, 64'sd1 <<< 60, ab, ns);
    return longint'(frac_div(64'd1 << 60, g[1], cb - 2));
  endfunction

  function automatic mat_t mat_mul(input mat_t a, input mat_t b, input int frac);
    mat_t   r;
    longint acc;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) begin
          acc = acc + mulq_c($signed(a[i*3+k]), $signed(b[k*3+j]), frac);
        end
        r[i*3+j] = acc;
      end
    end
    return r;
  endfunction

  // equatorial to galactic rotation, row-major
  function automatic mat_t rot_matrix(input int ab, input int ns, input int cb);
    longint one;
    longint k;
    pair_t  pa;
    pair_t  pb;
    pair_t  pc;
    mat_t   za;
    mat_t   xb;
    mat_t   zc;
    mat_t   m;
    one = 64'sd1 <<< (cb - 2);
    k   = kfix_c(ab, ns, cb);
    pa  = rotate_c(deg_to_ang(DEG_A, ab), k, ab, ns);
    pb  = rotate_c(deg_to_ang(DEG_B, ab), k, ab, ns);
    pc  = rotate_c(deg_to_ang(DEG_C, ab), k, ab, ns);
    za  = '0;
    xb  = '0;
    zc  = '0;
    za[0] = pa[1];  za[1] = -$signed(pa[0]); za[3] = pa[0];  za[4] = pa[1];  za[8] = one;
    xb[0] = one;    xb[4] = pb[1];  xb[5] = -$signed(pb[0]); xb[7] = pb[0];  xb[8] = pb[1];
    zc[0] = pc[1];  zc[1] = -$signed(pc[0]); zc[3] = pc[0];  zc[4] = pc[1];  zc[8] = one;
    m = mat_mul(xb, za, cb - 2);
    m = mat_mul(zc, m, cb - 2);
    return m;
  endfunction

endpackage

// ===== design/egc_mulq.sv =====
// ----------------------------------------------------------------------------
// egc_mulq
// registered fixed-point multiply, round half away from zero
// ----------------------------------------------------------------------------
module egc_mulq #(
  parameter int W    = 34,
  parameter int FRAC = 30
) (
  input  logic                clk_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic signed [W-1:0] p_o
);

  localparam logic [2*W-1:0] RND = (2*W)'(1) << (FRAC - 1);

  logic           neg;
  logic [W-1:0]   ua;
  logic [W-1:0]   ub;
  logic [2*W-1:0] prod;
  logic [2*W-1:0] rnd;
  logic [W-1:0]   mag;
  logic [W-1:0]   p_d;
  logic [W-1:0]   p_q;

  always_comb begin
    neg  = a_i[W-1] ^ b_i[W-1];
    ua   = a_i[W-1] ? W'(-a_i) : W'(a_i);
    ub   = b_i[W-1] ? W'(-b_i) : W'(b_i);
    prod = {W'(0), ua} * {W'(0), ub};
    rnd  = prod + RND;
    mag  = rnd[FRAC +: W];
    p_d  = neg ? W'(-mag) : mag;
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = $signed(p_q);

endmodule

// ===== design/egc_rot_cell.sv =====
// ----------------------------------------------------------------------------
// egc_rot_cell
// one rotation-mode cordic step for the longitude and latitude lanes
// ----------------------------------------------------------------------------
module egc_rot_cell #(
  parameter int W  = 34,
  parameter int AB = 32,
  parameter int I  = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  egc_pkg::rot_ctl_t      ctl_i,
  input  logic signed [W-1:0]    xl_i,
  input  logic signed [W-1:0]    yl_i,
  input  logic signed [AB+1:0]   zl_i,
  input  logic signed [W-1:0]    xb_i,
  input  logic signed [W-1:0]    yb_i,
  input  logic signed [AB+1:0]   zb_i,
  output egc_pkg::rot_ctl_t      ctl_o,
  output logic signed [W-1:0]    xl_o,
  output logic signed [W-1:0]    yl_o,
  output logic signed [AB+1:0]   zl_o,
  output logic signed [W-1:0]    xb_o,
  output logic signed [W-1:0]    yb_o,
  output logic signed [AB+1:0]   zb_o
);
  import egc_pkg::*;

  localparam int ZW = AB + 2;
  localparam logic signed [ZW-1:0] ATAB = ZW'(atan_tab(I, AB));

  rot_ctl_t             ctl_q;
  logic signed [W-1:0]  xl_d, yl_d, xb_d, yb_d;
  logic signed [W-1:0]  xl_q, yl_q, xb_q, yb_q;
  logic signed [ZW-1:0] zl_d, zb_d, zl_q, zb_q;

  always_comb begin
    if (!zl_i[ZW-1]) begin
      xl_d = xl_i - (yl_i >>> I);
      yl_d = yl_i + (xl_i >>> I);
      zl_d = zl_i - ATAB;
    end else begin
      xl_d = xl_i + (yl_i >>> I);
      yl_d = yl_i - (xl_i >>> I);
      zl_d = zl_i + ATAB;
    end
    if (!zb_i[ZW-1]) begin
      xb_d = xb_i - (yb_i >>> I);
      yb_d = yb_i + (xb_i >>> I);
      zb_d = zb_i - ATAB;
    end else begin
      xb_d = xb_i + (yb_i >>> I);
      yb_d = yb_i - (xb_i >>> I);
      zb_d = zb_i + ATAB;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    xl_q <= xl_d;
    yl_q <= yl_d;
    zl_q <= zl_d;
    xb_q <= xb_d;
    yb_q <= yb_d;
    zb_q <= zb_d;
  end

  assign ctl_o = ctl_q;
  assign xl_o  = xl_q;
  assign yl_o  = yl_q;
  assign zl_o  = zl_q;
  assign xb_o  = xb_q;
  assign yb_o  = yb_q;
  assign zb_o  = zb_q;

endmodule

// ===== design/egc_vec_cell.sv =====
// ----------------------------------------------------------------------------
// egc_vec_cell
// one vectoring-mode cordic step, carries a side word along
// ----------------------------------------------------------------------------
module egc_vec_cell #(
  parameter int W  = 34,
  parameter int AB = 32,
  parameter int SW = 32,
  parameter int I  = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  egc_pkg::vec_ctl_t   ctl_i,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  logic [AB-1:0]       z_i,
  input  logic [SW-1:0]       side_i,
  output egc_pkg::vec_ctl_t   ctl_o,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o,
  output logic [AB-1:0]       z_o,
  output logic [SW-1:0]       side_o
);
  import egc_pkg::*;

  localparam logic [AB-1:0] ATAB = AB'(atan_tab(I, AB));

  vec_ctl_t            ctl_q;
  logic signed [W-1:0] x_d, y_d, x_q, y_q;
  logic [AB-1:0]       z_d, z_q;
  logic [SW-1:0]       side_q;

  always_comb begin
    if (!y_i[W-1] && (y_i != '0)) begin
      x_d = x_i + (y_i >>> I);
      y_d = y_i - (x_i >>> I);
      z_d = z_i + ATAB;
    end else begin
      x_d = x_i - (y_i >>> I);
      y_d = y_i + (x_i >>> I);
      z_d = z_i - ATAB;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    side_q <= side_i;
  end

  assign ctl_o  = ctl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign side_o = side_q;

endmodule

// ===== design/equatorial_galactic_converter_unit.sv =====
// ----------------------------------------------------------------------------
// equatorial_galactic_converter_unit
// sky direction conversion between equatorial and galactic frames
//
// a word is taken at every rising edge where start is high and busy is low;
// busy never rises, so a new word can enter in every cycle
// the word carries req_type_i (0 equatorial to galactic, 1 the reverse),
// in_lon_i and in_lat_i as binary fractions of a full turn
// each word gives one result on out_lon_o / out_lat_o, shown for exactly one
// cycle with done_o high, in the same order as accepted
// the pipeline is the three cordic cell chains (sin/cos, longitude atan2,
// latitude atan2) and eight registers for input fold, vector products,
// matrix products, sum, the two vector setups, gain removal and output
// throughput is one word per clock, every cell hands its data on each cycle
// the receiver cannot hold results off; there is no back pressure anywhere
// reset clears every valid flag, so nothing is shown until new words arrive
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module equatorial_galactic_converter_unit #(
  parameter int ANGLE_BITS    = egc_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = egc_pkg::CORDIC_STAGES_DEF,
  parameter int COEF_BITS     = egc_pkg::COEF_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               req_type_i,
  input  logic [31:0]        in_lon_i,
  input  logic signed [31:0] in_lat_i,
  output logic               done_o,
  output logic [31:0]        out_lon_o,
  output logic signed [31:0] out_lat_o
);
  import egc_pkg::*;

  localparam int AB   = ANGLE_BITS;
  localparam int NS   = CORDIC_STAGES;
  localparam int W    = COEF_BITS + 2;
  localparam int FRAC = COEF_BITS - 2;
  localparam int ZW   = AB + 2;
  localparam int LAT  = 3 * NS + 8;

  localparam logic [AB-1:0] A_HALF    = AB'(1) << (AB - 1);
  localparam logic [AB-1:0] A_QUARTER = AB'(1) << (AB - 2);
  localparam logic signed [AB-1:0] LAT_MAX = $signed(A_QUARTER);
  localparam logic signed [AB-1:0] LAT_MIN = -LAT_MAX;

  // rotation matrix and inverse gain, built at elaboration
  localparam mat_t ROT = rot_matrix(AB, NS, COEF_BITS);
  localparam logic signed [W-1:0] KFIX = W'(kfix_c(AB, NS, COEF_BITS));

  // every word is taken
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // input scaling to the internal angle width and quadrant fold
  // --------------------------------------------------------------------------
  logic [AB-1:0] alon, alat;

  if (AB >= 32) begin : g_widen
    assign alon = AB'(in_lon_i) << (AB - 32);
    assign alat = AB'(in_lat_i) << (AB - 32);
  end else begin : g_narrow
    assign alon = AB'(in_lon_i >> (32 - AB));
    assign alat = AB'(in_lat_i >>> (32 - AB));
  end

  logic [AB-1:0] lon_sum, lat_sum, lon_f, lat_f;
  rot_ctl_t      s0_ctl_d, s0_ctl_q;
  logic signed [ZW-1:0] s0_zl_q, s0_zb_q;

  always_comb begin
    // angles beyond a quarter turn are folded by a half turn and the
    // result is negated at the end of the chain
    lon_sum          = alon + A_QUARTER;
    lat_sum          = alat + A_QUARTER;
    lon_f            = lon_sum[AB-1] ? (alon ^ A_HALF) : alon;
    lat_f            = lat_sum[AB-1] ? (alat ^ A_HALF) : alat;
    s0_ctl_d.valid   = start && !busy;
    s0_ctl_d.req     = req_type_i;
    s0_ctl_d.neg_lon = lon_sum[AB-1];
    s0_ctl_d.neg_lat = lat_sum[AB-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_ctl_q <= '0;
    end else begin
      s0_ctl_q <= s0_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_zl_q <= ZW'($signed(lon_f));
    s0_zb_q <= ZW'($signed(lat_f));
  end

  // --------------------------------------------------------------------------
  // sin/cos chain, both angles side by side
  // --------------------------------------------------------------------------
  rot_ctl_t             rc  [0:NS];
  logic signed [W-1:0]  rxl [0:NS];
  logic signed [W-1:0]  ryl [0:NS];
  logic signed [ZW-1:0] rzl [0:NS];
  logic signed [W-1:0]  rxb [0:NS];
  logic signed [W-1:0]  ryb [0:NS];
  logic signed [ZW-1:0] rzb [0:NS];

  assign rc[0]  = s0_ctl_q;
  assign rxl[0] = KFIX;
  assign ryl[0] = '0;
  assign rzl[0] = s0_zl_q;
  assign rxb[0] = KFIX;
  assign ryb[0] = '0;
  assign rzb[0] = s0_zb_q;

  for (genvar gi = 0; gi < NS; gi++) begin : g_rot
    egc_rot_cell #(.W(W), .AB(AB), .I(gi)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (rc[gi]),
      .xl_i   (rxl[gi]),
      .yl_i   (ryl[gi]),
      .zl_i   (rzl[gi]),
      .xb_i   (rxb[gi]),
      .yb_i   (ryb[gi]),
      .zb_i   (rzb[gi]),
      .ctl_o  (rc[gi+1]),
      .xl_o   (rxl[gi+1]),
      .yl_o   (ryl[gi+1]),
      .zl_o   (rzl[gi+1]),
      .xb_o   (rxb[gi+1]),
      .yb_o   (ryb[gi+1]),
      .zb_o   (rzb[gi+1])
    );
  end

  // undo the fold
  logic signed [W-1:0] cos_lon, sin_lon, cos_lat, sin_lat;

  always_comb begin
    cos_lon = rc[NS].neg_lon ? -rxl[NS] : rxl[NS];
    sin_lon = rc[NS].neg_lon ? -ryl[NS] : ryl[NS];
    cos_lat = rc[NS].neg_lat ? -rxb[NS] : rxb[NS];
    sin_lat = rc[NS].neg_lat ? -ryb[NS] : ryb[NS];
  end

  // --------------------------------------------------------------------------
  // unit vector (cos lon cos lat, sin lon cos lat, sin lat)
  // --------------------------------------------------------------------------
  logic signed [W-1:0] vv [0:2];
  logic                v_valid_q, v_req_q;
  logic signed [W-1:0] v2_q;

  egc_mulq #(.W(W), .FRAC(FRAC)) u_mul_v0 (
    .clk_i (clk_i), .a_i (cos_lon), .b_i (cos_lat), .p_o (vv[0])
  );
  egc_mulq #(.W(W), .FRAC(FRAC)) u_mul_v1 (
    .clk_i (clk_i), .a_i (sin_lon), .b_i (cos_lat), .p_o (vv[1])
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_valid_q <= 1'b0;
    end else begin
      v_valid_q <= rc[NS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    v_req_q <= rc[NS].req;
    v2_q    <= sin_lat;
  end

  assign vv[2] = v2_q;

  // --------------------------------------------------------------------------
  // matrix products, transpose selected for galactic to equatorial
  // --------------------------------------------------------------------------
  logic signed [W-1:0] prod [0:2][0:2];
  logic                m_valid_q;

  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      localparam logic signed [W-1:0] CF = W'($signed(ROT[gi*3+gj]));
      localparam logic signed [W-1:0] CT = W'($signed(ROT[gj*3+gi]));
      logic signed [W-1:0] coef;
      assign coef = v_req_q ? CT : CF;
      egc_mulq #(.W(W), .FRAC(FRAC)) u_mul_m (
        .clk_i (clk_i), .a_i (coef), .b_i (vv[gj]), .p_o (prod[gi][gj])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= v_valid_q;
    end
  end

  logic signed [W-1:0] u_q [0:2];
  logic                u_valid_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      u_q[i] <= prod[i][0] + prod[i][1] + prod[i][2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_valid_q <= 1'b0;
    end else begin
      u_valid_q <= m_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // longitude: atan2(u1, u0), left half plane turned by a half turn
  // --------------------------------------------------------------------------
  vec_ctl_t            p1_ctl_d, p1_ctl_q;
  logic signed [W-1:0] p1_x_q, p1_y_q, p1_side_q;
  logic [AB-1:0]       p1_z_q;

  always_comb begin
    p1_ctl_d.valid = u_valid_q;
    p1_ctl_d.pole  = (u_q[0] == '0) && (u_q[1] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_ctl_q <= '0;
    end else begin
      p1_ctl_q <= p1_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_x_q    <= u_q[0][W-1] ? -u_q[0] : u_q[0];
    p1_y_q    <= u_q[0][W-1] ? -u_q[1] : u_q[1];
    p1_z_q    <= u_q[0][W-1] ? A_HALF : '0;
    p1_side_q <= u_q[2];
  end

  vec_ctl_t            vc1 [0:NS];
  logic signed [W-1:0] vx1 [0:NS];
  logic signed [W-1:0] vy1 [0:NS];
  logic [AB-1:0]       vz1 [0:NS];
  logic [W-1:0]        vs1 [0:NS];

  assign vc1[0] = p1_ctl_q;
  assign vx1[0] = p1_x_q;
  assign vy1[0] = p1_y_q;
  assign vz1[0] = p1_z_q;
  assign vs1[0] = p1_side_q;

  for (genvar gi = 0; gi < NS; gi++) begin : g_vec1
    egc_vec_cell #(.W(W), .AB(AB), .SW(W), .I(gi)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (vc1[gi]),
      .x_i    (vx1[gi]),
      .y_i    (vy1[gi]),
      .z_i    (vz1[gi]),
      .side_i (vs1[gi]),
      .ctl_o  (vc1[gi+1]),
      .x_o    (vx1[gi+1]),
      .y_o    (vy1[gi+1]),
      .z_o    (vz1[gi+1]),
      .side_o (vs1[gi+1])
    );
  end

  // --------------------------------------------------------------------------
  // gain removal on the equatorial-plane magnitude
  // --------------------------------------------------------------------------
  logic signed [W-1:0] r_mag;
  logic                r_valid_q;
  logic [AB-1:0]       r_lon_q;
  logic signed [W-1:0] r_u2_q;

  egc_mulq #(.W(W), .FRAC(FRAC)) u_mul_r (
    .clk_i (clk_i), .a_i (vx1[NS]), .b_i (KFIX), .p_o (r_mag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else begin
      r_valid_q <= vc1[NS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    // pole: longitude forced to zero
    r_lon_q <= vc1[NS].pole ? '0 : vz1[NS];
    r_u2_q  <= $signed(vs1[NS]);
  end

  // --------------------------------------------------------------------------
  // latitude: atan2(u2, magnitude)
  // --------------------------------------------------------------------------
  vec_ctl_t            p2_ctl_d, p2_ctl_q;
  logic signed [W-1:0] p2_x_q, p2_y_q;
  logic [AB-1:0]       p2_z_q, p2_side_q;

  always_comb begin
    p2_ctl_d.valid = r_valid_q;
    p2_ctl_d.pole  = (r_mag == '0) && (r_u2_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_ctl_q <= '0;
    end else begin
      p2_ctl_q <= p2_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_x_q    <= r_mag[W-1] ? -r_mag : r_mag;
    p2_y_q    <= r_mag[W-1] ? -r_u2_q : r_u2_q;
    p2_z_q    <= r_mag[W-1] ? A_HALF : '0;
    p2_side_q <= r_lon_q;
  end

  vec_ctl_t            vc2 [0:NS];
  logic signed [W-1:0] vx2 [0:NS];
  logic signed [W-1:0] vy2 [0:NS];
  logic [AB-1:0]       vz2 [0:NS];
  logic [AB-1:0]       vs2 [0:NS];

  assign vc2[0] = p2_ctl_q;
  assign vx2[0] = p2_x_q;
  assign vy2[0] = p2_y_q;
  assign vz2[0] = p2_z_q;
  assign vs2[0] = p2_side_q;

  for (genvar gi = 0; gi < NS; gi++) begin : g_vec2
    egc_vec_cell #(.W(W), .AB(AB), .SW(AB), .I(gi)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (vc2[gi]),
      .x_i    (vx2[gi]),
      .y_i    (vy2[gi]),
      .z_i    (vz2[gi]),
      .side_i (vs2[gi]),
      .ctl_o  (vc2[gi+1]),
      .x_o    (vx2[gi+1]),
      .y_o    (vy2[gi+1]),
      .z_o    (vz2[gi+1]),
      .side_o (vs2[gi+1])
    );
  end

  // --------------------------------------------------------------------------
  // latitude clamp to plus or minus 90, narrowing to 32 bits
  // --------------------------------------------------------------------------
  logic signed [AB-1:0] lat_raw, lat_sat;
  logic [31:0]          lon_out;
  logic signed [31:0]   lat_out;

  always_comb begin
    lat_raw = vc2[NS].pole ? '0 : $signed(vz2[NS]);
    if (lat_raw > LAT_MAX) begin
      lat_sat = LAT_MAX;
    end else if (lat_raw < LAT_MIN) begin
      lat_sat = LAT_MIN;
    end else begin
      lat_sat = lat_raw;
    end
  end

  if (AB > 32) begin : g_out_round
    localparam int S = AB - 32;
    logic [AB:0]        lon_rnd;
    logic signed [AB:0] lat_rnd;
    always_comb begin
      // round half up; a longitude that rounds to a full turn wraps to zero
      lon_rnd = {1'b0, vs2[NS]} + ((AB + 1)'(1) << (S - 1));
      lat_rnd = (AB + 1)'(lat_sat) + ((AB + 1)'(1) << (S - 1));
      lon_out = lon_rnd[S +: 32];
      lat_out = 32'(lat_rnd >>> S);
    end
  end else begin : g_out_shift
    localparam int S = 32 - AB;
    always_comb begin
      lon_out = 32'(vs2[NS]) << S;
      lat_out = 32'(lat_sat) <<< S;
    end
  end

  logic               done_q;
  logic [31:0]        out_lon_q;
  logic signed [31:0] out_lat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vc2[NS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_lon_q <= lon_out;
    out_lat_q <= lat_out;
  end

  assign done_o    = done_q;
  assign out_lon_o = out_lon_q;
  assign out_lat_o = out_lat_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `EGC_ASSERT(a_fixed_latency, clk_i, rst_ni, (start && !busy) |-> ##LAT done_o, "word lost in pipe")
  `EGC_ASSERT(a_no_phantom, clk_i, rst_ni, done_o |-> $past(start, LAT), "result without word")
  `EGC_ASSERT_NEVER(a_lat_range, clk_i, rst_ni, done_o && ((out_lat_o > 32'sd1073741824) || (out_lat_o < -32'sd1073741824)), "latitude past pole")

endmodule
